### sv/dwsp_pkg.sv
// Shared types and constants for the dual wheel speed PI unit.
// Used by dwsp_recovery, dwsp_lane and the top level; depends on nothing.
package dwsp_pkg;

    // Lane pipeline depth (stages between input register and output register)
    localparam int unsigned NUM_STAGES = 6;

    // Fixed field widths
    localparam int unsigned CFG_W    = 20;
    localparam int unsigned TGT_W    = 18;
    localparam int unsigned SPD_W    = 32;
    localparam int unsigned DRV_W    = 16;
    localparam int unsigned DB_W     = 16;
    localparam int unsigned LIM_W    = 15;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned MAG_W    = 16;
    localparam int unsigned LERR_W   = 8;
    localparam int unsigned ACC_FRAC = 16;

    localparam logic signed [SPD_W-1:0] SPD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SPD_W-1:0] SPD_MIN = 32'sh8000_0000;

    // Request codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Recovery phases
    typedef enum logic [1:0] {
        PH_TRACK  = 2'd0,
        PH_SEARCH = 2'd1,
        PH_PIVOT  = 2'd2,
        PH_SPIN   = 2'd3
    } t_phase;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEGRAL_GAIN = 3'd1,
        CFG_DEAD_BAND     = 3'd2,
        CFG_DRIVE_LIMIT   = 3'd3,
        CFG_SEARCH_TICKS  = 3'd4,
        CFG_PIVOT_TICKS   = 3'd5,
        CFG_PIVOT_SPEED   = 3'd6,
        CFG_SPIN_SPEED    = 3'd7
    } t_cfg_idx;

    // Configuration reset values
    localparam logic [CFG_W-1:0]  RST_PROP_GAIN     = 20'd153600;
    localparam logic [CFG_W-1:0]  RST_INTEGRAL_GAIN = 20'd204800;
    localparam logic [DB_W-1:0]   RST_DEAD_BAND     = 16'd328;
    localparam logic [LIM_W-1:0]  RST_DRIVE_LIMIT   = 15'd7800;
    localparam logic [TICK_W-1:0] RST_SEARCH_TICKS  = 16'd20;
    localparam logic [TICK_W-1:0] RST_PIVOT_TICKS   = 16'd50;
    localparam logic [MAG_W-1:0]  RST_PIVOT_SPEED   = 16'd4588;
    localparam logic [MAG_W-1:0]  RST_SPIN_SPEED    = 16'd7209;

    // Per-stage control sent from the top level to both wheel lanes
    typedef struct packed {
        logic [NUM_STAGES:0] move;     // bit 0: item taken, bit k: item leaves stage k
        logic                flt_upd;  // stage 1 item is a control tick
        logic                prev_clr; // stage 3 item is a start
        logic                prev_upd; // stage 3 item is a running tick
        logic                acc_clr;  // stage 5 item is a start
        logic                acc_upd;  // stage 5 item is a running tick
    } t_lane_ctl;

    // Request information carried alongside the lane pipeline
    typedef struct packed {
        t_req   req;
        logic   run;
        t_phase phase;
    } t_op;

endpackage

### sv/dwsp_recovery.sv
// Run/stop mode and line-loss recovery: lost-tick counter, phase and target override.
// Depends on dwsp_pkg.
module dwsp_recovery (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_step,
    input  dwsp_pkg::t_req                       i_req,
    input  logic                                 i_line_lost,
    input  logic                                 i_turn_right,
    input  logic signed [dwsp_pkg::TGT_W-1:0]    i_trk_left,
    input  logic signed [dwsp_pkg::TGT_W-1:0]    i_trk_right,
    input  logic        [dwsp_pkg::TICK_W-1:0]   i_search_ticks,
    input  logic        [dwsp_pkg::TICK_W-1:0]   i_pivot_ticks,
    input  logic        [dwsp_pkg::MAG_W-1:0]    i_pivot_speed,
    input  logic        [dwsp_pkg::MAG_W-1:0]    i_spin_speed,
    output logic                                 o_running,
    output dwsp_pkg::t_phase                     o_phase,
    output logic signed [dwsp_pkg::TGT_W-1:0]    o_tgt_left,
    output logic signed [dwsp_pkg::TGT_W-1:0]    o_tgt_right
);

    logic                              r_running;
    logic [dwsp_pkg::TICK_W-1:0]       r_lost_cnt;
    logic                              n_running;
    logic [dwsp_pkg::TICK_W-1:0]       n_lost_cnt;
    logic [dwsp_pkg::MAG_W-1:0]        turn_mag;
    logic signed [dwsp_pkg::TGT_W-1:0] turn_tgt;

    // Mode and counter update for the item leaving stage 1
    always_comb begin
        n_running  = r_running;
        n_lost_cnt = r_lost_cnt;
        case (i_req)
            dwsp_pkg::REQ_START: begin
                n_running  = 1'b1;
                n_lost_cnt = '0;
            end
            dwsp_pkg::REQ_STOP: begin
                n_running  = 1'b0;
                n_lost_cnt = '0;
            end
            dwsp_pkg::REQ_TICK: begin
                if (!r_running || !i_line_lost) begin
                    n_lost_cnt = '0;
                end else if (r_lost_cnt != '1) begin
                    n_lost_cnt = r_lost_cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Phase after the update; spin is checked before pivot
    always_comb begin
        if (!n_running || n_lost_cnt == '0) begin
            o_phase = dwsp_pkg::PH_TRACK;
        end else if (n_lost_cnt > i_pivot_ticks) begin
            o_phase = dwsp_pkg::PH_SPIN;
        end else if (n_lost_cnt > i_search_ticks) begin
            o_phase = dwsp_pkg::PH_PIVOT;
        end else begin
            o_phase = dwsp_pkg::PH_SEARCH;
        end
    end

    // Target override: turn toward the side of the last line error
    assign turn_mag = (o_phase == dwsp_pkg::PH_SPIN) ? i_spin_speed : i_pivot_speed;
    assign turn_tgt = dwsp_pkg::TGT_W'($signed({1'b0, turn_mag}));

    always_comb begin
        if (o_phase inside {dwsp_pkg::PH_PIVOT, dwsp_pkg::PH_SPIN}) begin
            o_tgt_left  = i_turn_right ? turn_tgt : -turn_tgt;
            o_tgt_right = i_turn_right ? -turn_tgt : turn_tgt;
        end else begin
            o_tgt_left  = i_trk_left;
            o_tgt_right = i_trk_right;
        end
    end

    assign o_running = n_running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_lost_cnt <= '0;
        end else if (i_step) begin
            r_running  <= n_running;
            r_lost_cnt <= n_lost_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    // the counter only runs while the motors run
    a_lost_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_lost_cnt == '0))
        else $error("lost-tick counter non-zero while stopped");
`endif

endmodule

### sv/dwsp_lane.sv
// One wheel lane: encoder scaling, speed filter, error with deadband and incremental PI.
// Depends on dwsp_pkg; control arrives from the top level as a t_lane_ctl struct.
module dwsp_lane #(
    parameter int unsigned SPEED_FRAC_BITS = 16,
    parameter int unsigned GAIN_FRAC_BITS  = 8,
    parameter int unsigned COUNT_WIDTH     = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dwsp_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [COUNT_WIDTH:0]           i_count,
    input  logic signed [dwsp_pkg::TGT_W-1:0]     i_target,
    input  logic        [dwsp_pkg::CFG_W-1:0]     i_prop_gain,
    input  logic        [dwsp_pkg::CFG_W-1:0]     i_integral_gain,
    input  logic        [dwsp_pkg::DB_W-1:0]      i_dead_band,
    input  logic        [dwsp_pkg::LIM_W-1:0]     i_drive_limit,
    output logic signed [dwsp_pkg::SPD_W-1:0]     o_speed,
    output logic signed [dwsp_pkg::DRV_W-1:0]     o_drive
);

    localparam int unsigned SPD_W = dwsp_pkg::SPD_W;
    // encoder count to speed: round(2^(SPEED_FRAC_BITS+8) * 0.0008)
    localparam longint unsigned SCALE =
        ((64'd1 << (SPEED_FRAC_BITS + 8)) * 64'd8 + 64'd5000) / 64'd10000;
    localparam int unsigned SCALE_W = $clog2(SCALE + 1) + 1;
    localparam int unsigned CNT_W   = COUNT_WIDTH + 1;
    localparam int unsigned PROD_W  = CNT_W + SCALE_W;
    localparam int unsigned RAW_W   = PROD_W - 8;
    localparam int unsigned FLT_W   = ((RAW_W > SPD_W) ? RAW_W : SPD_W) + 10;
    localparam int          PI_SHIFT = int'(GAIN_FRAC_BITS + SPEED_FRAC_BITS)
                                       - int'(dwsp_pkg::ACC_FRAC);
    localparam int unsigned SHR     = (PI_SHIFT > 0) ? PI_SHIFT : 0;
    localparam int unsigned SHL     = (PI_SHIFT < 0) ? -PI_SHIFT : 0;
    localparam int unsigned ERR_W   = SPD_W + 1;
    localparam int unsigned GAIN_W  = dwsp_pkg::CFG_W + 1;
    localparam int unsigned PRD_W   = GAIN_W + ERR_W;
    localparam int unsigned SUM_W   = PRD_W + 1;
    localparam int unsigned INC_W   = SUM_W + SHL;
    localparam int unsigned ACC_W   = INC_W + 1;

    localparam logic signed [SCALE_W-1:0] SCALE_S = SCALE_W'(SCALE);
    localparam logic signed [8:0]         K_NEW   = 9'sd102;
    localparam logic signed [8:0]         K_OLD   = 9'sd154;
    localparam logic signed [SPD_W:0]     RND_NEG =
        (SPD_W + 1)'((64'd1 << dwsp_pkg::ACC_FRAC) - 64'd1);
    localparam logic signed [SPD_W:0]     RND_ZERO = '0;

    // state
    logic signed [SPD_W-1:0] r_filt;
    logic signed [SPD_W-1:0] r_prev;
    logic signed [SPD_W-1:0] r_acc;

    // pipeline payload
    logic signed [RAW_W-1:0] r_raw;
    logic signed [SPD_W-1:0] r_spd2, r_spd3, r_spd4, r_spd5, r_spd6;
    logic signed [dwsp_pkg::TGT_W-1:0] r_tgt2;
    logic signed [SPD_W-1:0] r_err3;
    logic                    r_dead3, r_dead4, r_dead5;
    logic signed [PRD_W-1:0] r_p4, r_q4;
    logic signed [INC_W-1:0] r_inc5;
    logic signed [SPD_W-1:0] r_acc6;

    logic signed [PROD_W-1:0] prod0;
    logic signed [FLT_W-1:0]  flt_sum, flt_q;
    logic signed [SPD_W-1:0]  n_spd;
    logic signed [ERR_W-1:0]  err_diff, err_x, err_mag, db_x, err_d;
    logic signed [SPD_W-1:0]  n_err;
    logic signed [GAIN_W-1:0] prop_x, intg_x;
    logic signed [SUM_W-1:0]  pi_sum;
    logic signed [INC_W-1:0]  n_inc;
    logic signed [ACC_W-1:0]  acc_sum, lim_x;
    logic signed [SPD_W-1:0]  acc_clip, n_acc, n_prev;
    logic signed [SPD_W:0]    acc_rnd;

    // stage 0: count times scale, floor by 256
    assign prod0 = i_count * SCALE_S;

    // stage 1: first-order filter, 102/256 new + 154/256 old, saturated
    assign flt_sum = FLT_W'(r_raw) * K_NEW + FLT_W'(r_filt) * K_OLD;
    assign flt_q   = flt_sum >>> 8;
    assign n_spd   = (flt_q > FLT_W'(dwsp_pkg::SPD_MAX)) ? dwsp_pkg::SPD_MAX :
                     (flt_q < FLT_W'(dwsp_pkg::SPD_MIN)) ? dwsp_pkg::SPD_MIN :
                     SPD_W'(flt_q);

    // stage 2: speed error, saturated, and deadband test
    assign err_diff = ERR_W'(r_tgt2) - ERR_W'(r_spd2);
    assign n_err    = (err_diff > ERR_W'(dwsp_pkg::SPD_MAX)) ? dwsp_pkg::SPD_MAX :
                      (err_diff < ERR_W'(dwsp_pkg::SPD_MIN)) ? dwsp_pkg::SPD_MIN :
                      SPD_W'(err_diff);
    assign err_x    = ERR_W'(n_err);
    assign err_mag  = (err_x < 0) ? -err_x : err_x;
    assign db_x     = ERR_W'($signed({1'b0, i_dead_band}));

    // stage 3: proportional and integral products
    assign err_d  = ERR_W'(r_err3) - ERR_W'(r_prev);
    assign prop_x = $signed({1'b0, i_prop_gain});
    assign intg_x = $signed({1'b0, i_integral_gain});
    assign n_prev = i_ctl.prev_clr ? '0 : (i_ctl.prev_upd ? r_err3 : r_prev);

    // stage 4: sum and rescale to Q16 drive units
    assign pi_sum = SUM_W'(r_p4) + SUM_W'(r_q4);
    assign n_inc  = (INC_W'(pi_sum) <<< SHL) >>> SHR;

    // stage 5: accumulate and clamp to the drive limit
    assign acc_sum  = ACC_W'(r_acc) + ACC_W'(r_inc5);
    assign lim_x    = ACC_W'($signed({1'b0, i_drive_limit, {dwsp_pkg::ACC_FRAC{1'b0}}}));
    assign acc_clip = (acc_sum > lim_x)  ? SPD_W'(lim_x)  :
                      (acc_sum < -lim_x) ? SPD_W'(-lim_x) :
                      SPD_W'(acc_sum);
    assign n_acc    = i_ctl.acc_clr ? '0 :
                      ((i_ctl.acc_upd && !r_dead5) ? acc_clip : r_acc);

    // stage 6: drive, truncated toward zero
    assign acc_rnd = (SPD_W + 1)'(r_acc6) + (r_acc6[SPD_W-1] ? RND_NEG : RND_ZERO);
    assign o_drive = dwsp_pkg::DRV_W'(acc_rnd >>> dwsp_pkg::ACC_FRAC);
    assign o_speed = r_spd6;

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
            r_prev <= '0;
            r_acc  <= '0;
        end else begin
            if (i_ctl.move[1] && i_ctl.flt_upd) begin
                r_filt <= n_spd;
            end
            if (i_ctl.move[3]) begin
                r_prev <= n_prev;
            end
            if (i_ctl.move[5]) begin
                r_acc <= n_acc;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.move[0]) begin
            r_raw <= RAW_W'(prod0 >>> 8);
        end
        if (i_ctl.move[1]) begin
            r_spd2 <= i_ctl.flt_upd ? n_spd : r_filt;
            r_tgt2 <= i_target;
        end
        if (i_ctl.move[2]) begin
            r_spd3  <= r_spd2;
            r_err3  <= n_err;
            r_dead3 <= err_mag < db_x;
        end
        if (i_ctl.move[3]) begin
            r_spd4  <= r_spd3;
            r_dead4 <= r_dead3;
            r_p4    <= PRD_W'(prop_x) * PRD_W'(err_d);
            r_q4    <= PRD_W'(intg_x) * PRD_W'(r_err3);
        end
        if (i_ctl.move[4]) begin
            r_spd5  <= r_spd4;
            r_dead5 <= r_dead4;
            r_inc5  <= n_inc;
        end
        if (i_ctl.move[5]) begin
            r_spd6 <= r_spd5;
            r_acc6 <= n_acc;
        end
    end

`ifndef NO_ASSERTIONS
    // a start leaves the accumulator empty
    a_start_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.move[5] && i_ctl.acc_clr) |=> (r_acc == '0))
        else $error("accumulator not cleared by start");
`endif

endmodule

### sv/dual_wheel_speed_pi_with_line_recovery_unit.sv
// Top level: configuration registers, pipeline flow control, recovery logic,
// two wheel lanes and the merging output register. Depends on dwsp_pkg,
// dwsp_recovery and dwsp_lane.
//
// Two-wheel speed controller with line-loss recovery. Each item is a control
// tick, a start, a stop or a status request and gives exactly one result. An
// item is taken every clock while the output side is not stalled; its result
// passes through the six stages of each wheel lane (encoder scaling multiply,
// speed filter, error and deadband, the two gain multiplies, increment
// rescale, accumulator clamp) and then the output register that merges the
// two lanes. Bubbles in the pipeline close up while the output is stalled, so
// up to seven items can be held. No clearing pass follows reset.
// Configuration writes take effect at once and are meant for when no item is
// in flight.
module dual_wheel_speed_pi_with_line_recovery_unit #(
    parameter int unsigned SPEED_FRAC_BITS = 16,
    parameter int unsigned GAIN_FRAC_BITS  = 8,
    parameter int unsigned COUNT_WIDTH     = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic        [2:0]                   i_cfg_idx,
    input  logic        [dwsp_pkg::CFG_W-1:0]   i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic        [1:0]                   i_req_type,
    input  logic signed [COUNT_WIDTH-1:0]       i_count_left,
    input  logic signed [COUNT_WIDTH-1:0]       i_count_right,
    input  logic signed [dwsp_pkg::TGT_W-1:0]   i_tracker_target_left,
    input  logic signed [dwsp_pkg::TGT_W-1:0]   i_tracker_target_right,
    input  logic                                i_line_lost,
    input  logic signed [dwsp_pkg::LERR_W-1:0]  i_last_line_error,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [dwsp_pkg::DRV_W-1:0]   o_drive_left,
    output logic signed [dwsp_pkg::DRV_W-1:0]   o_drive_right,
    output logic                                o_motors_stopped,
    output logic        [1:0]                   o_recovery_phase,
    output logic signed [dwsp_pkg::SPD_W-1:0]   o_speed_left,
    output logic signed [dwsp_pkg::SPD_W-1:0]   o_speed_right
);

    localparam int unsigned NSTG  = dwsp_pkg::NUM_STAGES;
    localparam int unsigned CNT_W = COUNT_WIDTH + 1;

    // configuration registers
    logic [dwsp_pkg::CFG_W-1:0]  r_prop_gain;
    logic [dwsp_pkg::CFG_W-1:0]  r_integral_gain;
    logic [dwsp_pkg::DB_W-1:0]   r_dead_band;
    logic [dwsp_pkg::LIM_W-1:0]  r_drive_limit;
    logic [dwsp_pkg::TICK_W-1:0] r_search_ticks;
    logic [dwsp_pkg::TICK_W-1:0] r_pivot_ticks;
    logic [dwsp_pkg::MAG_W-1:0]  r_pivot_speed;
    logic [dwsp_pkg::MAG_W-1:0]  r_spin_speed;

    // flow control
    logic [NSTG:1]    r_vld;
    logic             r_out_vld;
    logic [NSTG+1:1]  free;
    logic [NSTG:0]    mv;

    // stage 1 request fields and per-stage request info
    dwsp_pkg::t_req                    r_s1_req;
    logic                              r_s1_lost;
    logic                              r_s1_right;
    logic signed [dwsp_pkg::TGT_W-1:0] r_s1_trk_l;
    logic signed [dwsp_pkg::TGT_W-1:0] r_s1_trk_r;
    dwsp_pkg::t_op                     r_op [2:NSTG];

    // recovery outputs
    logic                              rec_running;
    dwsp_pkg::t_phase                  rec_phase;
    logic signed [dwsp_pkg::TGT_W-1:0] rec_tgt_l;
    logic signed [dwsp_pkg::TGT_W-1:0] rec_tgt_r;

    // lanes
    dwsp_pkg::t_lane_ctl               lane_ctl;
    logic signed [CNT_W-1:0]           cnt_l, cnt_r;
    logic signed [dwsp_pkg::SPD_W-1:0] spd_l, spd_r;
    logic signed [dwsp_pkg::DRV_W-1:0] drv_l, drv_r;
    logic                              drv_en;

    // output register
    logic signed [dwsp_pkg::DRV_W-1:0] r_out_drv_l, r_out_drv_r;
    logic                              r_out_stopped;
    dwsp_pkg::t_phase                  r_out_phase;
    logic signed [dwsp_pkg::SPD_W-1:0] r_out_spd_l, r_out_spd_r;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= dwsp_pkg::RST_PROP_GAIN;
            r_integral_gain <= dwsp_pkg::RST_INTEGRAL_GAIN;
            r_dead_band     <= dwsp_pkg::RST_DEAD_BAND;
            r_drive_limit   <= dwsp_pkg::RST_DRIVE_LIMIT;
            r_search_ticks  <= dwsp_pkg::RST_SEARCH_TICKS;
            r_pivot_ticks   <= dwsp_pkg::RST_PIVOT_TICKS;
            r_pivot_speed   <= dwsp_pkg::RST_PIVOT_SPEED;
            r_spin_speed    <= dwsp_pkg::RST_SPIN_SPEED;
        end else if (i_cfg_we) begin
            case (dwsp_pkg::t_cfg_idx'(i_cfg_idx))
                dwsp_pkg::CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                dwsp_pkg::CFG_INTEGRAL_GAIN: r_integral_gain <= i_cfg_data;
                dwsp_pkg::CFG_DEAD_BAND:     r_dead_band     <= i_cfg_data[dwsp_pkg::DB_W-1:0];
                dwsp_pkg::CFG_DRIVE_LIMIT:   r_drive_limit   <= i_cfg_data[dwsp_pkg::LIM_W-1:0];
                dwsp_pkg::CFG_SEARCH_TICKS:  r_search_ticks  <= i_cfg_data[dwsp_pkg::TICK_W-1:0];
                dwsp_pkg::CFG_PIVOT_TICKS:   r_pivot_ticks   <= i_cfg_data[dwsp_pkg::TICK_W-1:0];
                dwsp_pkg::CFG_PIVOT_SPEED:   r_pivot_speed   <= i_cfg_data[dwsp_pkg::MAG_W-1:0];
                dwsp_pkg::CFG_SPIN_SPEED:    r_spin_speed    <= i_cfg_data[dwsp_pkg::MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // per-stage flow: an item moves on when the next stage is empty or moving
    always_comb begin
        free[NSTG+1] = !r_out_vld || !i_out_stall;
        for (int k = NSTG; k >= 1; k--) begin
            mv[k]   = r_vld[k] && free[k+1];
            free[k] = !r_vld[k] || mv[k];
        end
        mv[0] = i_in_valid && free[1];
    end

    assign o_in_stall = !free[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                r_vld[k] <= mv[k-1] || (r_vld[k] && !mv[k]);
            end
            r_out_vld <= mv[NSTG] || (r_out_vld && i_out_stall);
        end
    end

    // stage 1 request fields and request info travelling with the lanes
    always_ff @(posedge i_clk) begin
        if (mv[0]) begin
            r_s1_req   <= dwsp_pkg::t_req'(i_req_type);
            r_s1_lost  <= i_line_lost;
            r_s1_right <= !i_last_line_error[dwsp_pkg::LERR_W-1];
            r_s1_trk_l <= i_tracker_target_left;
            r_s1_trk_r <= i_tracker_target_right;
        end
        if (mv[1]) begin
            r_op[2] <= '{req: r_s1_req, run: rec_running, phase: rec_phase};
        end
        for (int k = 3; k <= NSTG; k++) begin
            if (mv[k-1]) begin
                r_op[k] <= r_op[k-1];
            end
        end
    end

    dwsp_recovery u_recovery (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (mv[1]),
        .i_req          (r_s1_req),
        .i_line_lost    (r_s1_lost),
        .i_turn_right   (r_s1_right),
        .i_trk_left     (r_s1_trk_l),
        .i_trk_right    (r_s1_trk_r),
        .i_search_ticks (r_search_ticks),
        .i_pivot_ticks  (r_pivot_ticks),
        .i_pivot_speed  (r_pivot_speed),
        .i_spin_speed   (r_spin_speed),
        .o_running      (rec_running),
        .o_phase        (rec_phase),
        .o_tgt_left     (rec_tgt_l),
        .o_tgt_right    (rec_tgt_r)
    );

    // lane control
    always_comb begin
        lane_ctl.move     = mv;
        lane_ctl.flt_upd  = (r_s1_req == dwsp_pkg::REQ_TICK);
        lane_ctl.prev_clr = (r_op[3].req == dwsp_pkg::REQ_START);
        lane_ctl.prev_upd = (r_op[3].req == dwsp_pkg::REQ_TICK) && r_op[3].run;
        lane_ctl.acc_clr  = (r_op[5].req == dwsp_pkg::REQ_START);
        lane_ctl.acc_upd  = (r_op[5].req == dwsp_pkg::REQ_TICK) && r_op[5].run;
    end

    // right encoder is mounted reversed; negate one bit wider
    assign cnt_l = CNT_W'(i_count_left);
    assign cnt_r = -(CNT_W'(i_count_right));

    dwsp_lane #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_lane_left (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (lane_ctl),
        .i_count         (cnt_l),
        .i_target        (rec_tgt_l),
        .i_prop_gain     (r_prop_gain),
        .i_integral_gain (r_integral_gain),
        .i_dead_band     (r_dead_band),
        .i_drive_limit   (r_drive_limit),
        .o_speed         (spd_l),
        .o_drive         (drv_l)
    );

    dwsp_lane #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_lane_right (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (lane_ctl),
        .i_count         (cnt_r),
        .i_target        (rec_tgt_r),
        .i_prop_gain     (r_prop_gain),
        .i_integral_gain (r_integral_gain),
        .i_dead_band     (r_dead_band),
        .i_drive_limit   (r_drive_limit),
        .o_speed         (spd_r),
        .o_drive         (drv_r)
    );

    // merge: drives show only for running ticks and status reads
    assign drv_en = r_op[NSTG].run
                 && (r_op[NSTG].req inside {dwsp_pkg::REQ_TICK, dwsp_pkg::REQ_NONE});

    always_ff @(posedge i_clk) begin
        if (mv[NSTG]) begin
            r_out_drv_l   <= drv_en ? drv_l : '0;
            r_out_drv_r   <= drv_en ? drv_r : '0;
            r_out_stopped <= !r_op[NSTG].run;
            r_out_phase   <= r_op[NSTG].phase;
            r_out_spd_l   <= spd_l;
            r_out_spd_r   <= spd_r;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_drive_left     = r_out_drv_l;
    assign o_drive_right    = r_out_drv_r;
    assign o_motors_stopped = r_out_stopped;
    assign o_recovery_phase = r_out_phase;
    assign o_speed_left     = r_out_spd_l;
    assign o_speed_right    = r_out_spd_r;

`ifndef NO_ASSERTIONS
    // stopped results carry no drive and no recovery phase
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_motors_stopped) |->
            (o_drive_left == '0 && o_drive_right == '0
             && o_recovery_phase == dwsp_pkg::PH_TRACK))
        else $error("stopped result with drive or phase set");

    // an item held in the last lane stage keeps its request info
    a_last_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG] && !mv[NSTG]) |=> (r_vld[NSTG] && $stable(r_op[NSTG])))
        else $error("last stage item lost or changed while held");

    // no new item is taken while stage 1 is full and cannot drain
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !free[2]) |-> !mv[0])
        else $error("item taken into a blocked stage");
`endif

endmodule

### test/dual_wheel_speed_pi_with_line_recovery_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dual wheel speed PI unit with line recovery.
// Needs dwsp_pkg and the unit's top level; a bit-exact predictor runs in-line.
module dual_wheel_speed_pi_with_line_recovery_unit_tb;

    localparam int     CLK_HALF        = 2;
    localparam int     CNT_W           = 16;
    localparam longint SPEED_SCALE     = 13422;   // Q16 speed per pulse, times 256
    localparam longint FILT_NEW        = 102;     // weight of the new sample, /256
    localparam longint FILT_OLD        = 154;
    localparam int     PI_SHIFT        = 8;       // gain fraction + speed fraction - 16
    localparam int     SPEED_PER_COUNT = 52;      // rough Q16 speed of one pulse
    localparam int     LOST_MAX        = 65535;
    localparam int     LONG_LOSS_TICKS = 60;
    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     RANDOM_SEGMENTS = 8;
    localparam int     SEGMENT_ITEMS   = 85;

    typedef struct {
        dwsp_pkg::t_req                     req;
        logic signed [CNT_W-1:0]            count_l;
        logic signed [CNT_W-1:0]            count_r;
        logic signed [dwsp_pkg::TGT_W-1:0]  target_l;
        logic signed [dwsp_pkg::TGT_W-1:0]  target_r;
        logic                               line_lost;
        logic signed [dwsp_pkg::LERR_W-1:0] line_err;
    } t_tick_item;

    typedef struct {
        logic signed [dwsp_pkg::DRV_W-1:0] drive_l;
        logic signed [dwsp_pkg::DRV_W-1:0] drive_r;
        logic                              stopped;
        logic [1:0]                        phase;
        logic signed [dwsp_pkg::SPD_W-1:0] speed_l;
        logic signed [dwsp_pkg::SPD_W-1:0] speed_r;
    } t_drive_result;

    typedef logic [7:0][dwsp_pkg::CFG_W-1:0] t_cfg_set;

    // DUT ports
    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [2:0]                         i_cfg_idx;
    logic [dwsp_pkg::CFG_W-1:0]         i_cfg_data;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic [1:0]                         i_req_type;
    logic signed [CNT_W-1:0]            i_count_left;
    logic signed [CNT_W-1:0]            i_count_right;
    logic signed [dwsp_pkg::TGT_W-1:0]  i_tracker_target_left;
    logic signed [dwsp_pkg::TGT_W-1:0]  i_tracker_target_right;
    logic                               i_line_lost;
    logic signed [dwsp_pkg::LERR_W-1:0] i_last_line_error;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic signed [dwsp_pkg::DRV_W-1:0]  o_drive_left;
    logic signed [dwsp_pkg::DRV_W-1:0]  o_drive_right;
    logic                               o_motors_stopped;
    logic [1:0]                         o_recovery_phase;
    logic signed [dwsp_pkg::SPD_W-1:0]  o_speed_left;
    logic signed [dwsp_pkg::SPD_W-1:0]  o_speed_right;

    // Predictor state and configuration copy
    logic [dwsp_pkg::CFG_W-1:0]         cfg_regs [8];
    logic signed [dwsp_pkg::SPD_W-1:0]  speed_est_l, speed_est_r;
    logic signed [dwsp_pkg::SPD_W-1:0]  prev_err_l, prev_err_r;
    logic signed [dwsp_pkg::SPD_W-1:0]  drive_acc_l, drive_acc_r;
    logic [dwsp_pkg::TICK_W-1:0]        lost_ticks;
    logic                               is_running;

    t_drive_result             expected_drive_q [$];
    int                        errors;
    int                        send_idle_pct;
    int                        recv_stall_pct;
    int                        idle_cycles;

    dual_wheel_speed_pi_with_line_recovery_unit i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_req_type             (i_req_type),
        .i_count_left           (i_count_left),
        .i_count_right          (i_count_right),
        .i_tracker_target_left  (i_tracker_target_left),
        .i_tracker_target_right (i_tracker_target_right),
        .i_line_lost            (i_line_lost),
        .i_last_line_error      (i_last_line_error),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_drive_left           (o_drive_left),
        .o_drive_right          (o_drive_right),
        .o_motors_stopped       (o_motors_stopped),
        .o_recovery_phase       (o_recovery_phase),
        .o_speed_left           (o_speed_left),
        .o_speed_right          (o_speed_right)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_long(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic logic signed [dwsp_pkg::SPD_W-1:0] sat_speed(longint x);
        longint c;
        c = clamp_long(x, -64'sd2147483648, 64'sd2147483647);
        return c[dwsp_pkg::SPD_W-1:0];
    endfunction

    // Pulse count to Q16 speed, then first-order low-pass
    function automatic logic signed [dwsp_pkg::SPD_W-1:0] filter_speed(
        longint cnt, logic signed [dwsp_pkg::SPD_W-1:0] old);
        longint raw;
        raw = (cnt * SPEED_SCALE) >>> 8;
        return sat_speed((FILT_NEW * raw + FILT_OLD * longint'(old)) >>> 8);
    endfunction

    // Accumulator to drive value, truncated toward zero
    function automatic logic signed [dwsp_pkg::DRV_W-1:0] drive_of(
        logic signed [dwsp_pkg::SPD_W-1:0] acc);
        longint a;
        longint d;
        a = acc;
        d = (a < 0) ? -((-a) >>> dwsp_pkg::ACC_FRAC) : (a >>> dwsp_pkg::ACC_FRAC);
        return d[dwsp_pkg::DRV_W-1:0];
    endfunction

    function automatic int cfg_width(dwsp_pkg::t_cfg_idx idx);
        case (idx)
            dwsp_pkg::CFG_PROP_GAIN, dwsp_pkg::CFG_INTEGRAL_GAIN: return dwsp_pkg::CFG_W;
            dwsp_pkg::CFG_DEAD_BAND:                              return dwsp_pkg::DB_W;
            dwsp_pkg::CFG_DRIVE_LIMIT:                            return dwsp_pkg::LIM_W;
            dwsp_pkg::CFG_SEARCH_TICKS, dwsp_pkg::CFG_PIVOT_TICKS: return dwsp_pkg::TICK_W;
            default:                                              return dwsp_pkg::MAG_W;
        endcase
    endfunction

    // Spin is checked first, so reversed thresholds still give spin
    function automatic dwsp_pkg::t_phase phase_now();
        if (!is_running || lost_ticks == 0)
            return dwsp_pkg::PH_TRACK;
        if (lost_ticks > cfg_regs[dwsp_pkg::CFG_PIVOT_TICKS])
            return dwsp_pkg::PH_SPIN;
        if (lost_ticks > cfg_regs[dwsp_pkg::CFG_SEARCH_TICKS])
            return dwsp_pkg::PH_PIVOT;
        return dwsp_pkg::PH_SEARCH;
    endfunction

    // Incremental PI with deadband; prev error moves even inside the band
    task automatic pi_wheel_step(input longint target,
                                 input logic signed [dwsp_pkg::SPD_W-1:0] speed,
                                 inout logic signed [dwsp_pkg::SPD_W-1:0] prev_err,
                                 inout logic signed [dwsp_pkg::SPD_W-1:0] acc);
        longint err;
        longint mag;
        longint sum;
        longint lim;
        longint nxt;
        err = longint'(sat_speed(target - longint'(speed)));
        mag = (err < 0) ? -err : err;
        if (mag >= longint'(cfg_regs[dwsp_pkg::CFG_DEAD_BAND])) begin
            sum = longint'(cfg_regs[dwsp_pkg::CFG_PROP_GAIN]) * (err - longint'(prev_err))
                + longint'(cfg_regs[dwsp_pkg::CFG_INTEGRAL_GAIN]) * err;
            lim = longint'(cfg_regs[dwsp_pkg::CFG_DRIVE_LIMIT]) <<< dwsp_pkg::ACC_FRAC;
            nxt = clamp_long(longint'(acc) + (sum >>> PI_SHIFT), -lim, lim);
            acc = nxt[dwsp_pkg::SPD_W-1:0];
        end
        prev_err = err[dwsp_pkg::SPD_W-1:0];
    endtask

    task automatic predict_step(input t_tick_item it, output t_drive_result res);
        longint                            tgt_l;
        longint                            tgt_r;
        longint                            mag;
        logic signed [dwsp_pkg::DRV_W-1:0] dl;
        logic signed [dwsp_pkg::DRV_W-1:0] dr;
        dwsp_pkg::t_phase                  ph;
        dl = '0;
        dr = '0;
        case (it.req)
            dwsp_pkg::REQ_START: begin
                prev_err_l  = '0;
                prev_err_r  = '0;
                drive_acc_l = '0;
                drive_acc_r = '0;
                lost_ticks  = '0;
                is_running  = 1'b1;
            end
            dwsp_pkg::REQ_STOP: begin
                is_running = 1'b0;
                lost_ticks = '0;
            end
            dwsp_pkg::REQ_NONE: begin
                // status only; drives show the accumulators while running
                if (is_running) begin
                    dl = drive_of(drive_acc_l);
                    dr = drive_of(drive_acc_r);
                end
            end
            dwsp_pkg::REQ_TICK: begin
                speed_est_l = filter_speed(longint'(it.count_l), speed_est_l);
                speed_est_r = filter_speed(-longint'(it.count_r), speed_est_r);
                if (!is_running) begin
                    lost_ticks = '0;
                end else begin
                    tgt_l = it.target_l;
                    tgt_r = it.target_r;
                    if (!it.line_lost)
                        lost_ticks = '0;
                    else if (lost_ticks != dwsp_pkg::TICK_W'(LOST_MAX))
                        lost_ticks = lost_ticks + 1'b1;
                    ph = phase_now();
                    // pivot and spin override the tracker, turning toward the last error
                    if (ph == dwsp_pkg::PH_PIVOT || ph == dwsp_pkg::PH_SPIN) begin
                        mag = (ph == dwsp_pkg::PH_SPIN)
                            ? longint'(cfg_regs[dwsp_pkg::CFG_SPIN_SPEED])
                            : longint'(cfg_regs[dwsp_pkg::CFG_PIVOT_SPEED]);
                        tgt_l = (it.line_err >= 0) ? mag : -mag;
                        tgt_r = -tgt_l;
                    end
                    pi_wheel_step(tgt_l, speed_est_l, prev_err_l, drive_acc_l);
                    pi_wheel_step(tgt_r, speed_est_r, prev_err_r, drive_acc_r);
                    dl = drive_of(drive_acc_l);
                    dr = drive_of(drive_acc_r);
                end
            end
        endcase
        res.drive_l = dl;
        res.drive_r = dr;
        res.stopped = !is_running;
        res.phase   = phase_now();
        res.speed_l = speed_est_l;
        res.speed_r = speed_est_r;
    endtask

    function automatic t_cfg_set default_settings();
        t_cfg_set s;
        s[dwsp_pkg::CFG_PROP_GAIN]     = dwsp_pkg::RST_PROP_GAIN;
        s[dwsp_pkg::CFG_INTEGRAL_GAIN] = dwsp_pkg::RST_INTEGRAL_GAIN;
        s[dwsp_pkg::CFG_DEAD_BAND]     = dwsp_pkg::CFG_W'(dwsp_pkg::RST_DEAD_BAND);
        s[dwsp_pkg::CFG_DRIVE_LIMIT]   = dwsp_pkg::CFG_W'(dwsp_pkg::RST_DRIVE_LIMIT);
        s[dwsp_pkg::CFG_SEARCH_TICKS]  = dwsp_pkg::CFG_W'(dwsp_pkg::RST_SEARCH_TICKS);
        s[dwsp_pkg::CFG_PIVOT_TICKS]   = dwsp_pkg::CFG_W'(dwsp_pkg::RST_PIVOT_TICKS);
        s[dwsp_pkg::CFG_PIVOT_SPEED]   = dwsp_pkg::CFG_W'(dwsp_pkg::RST_PIVOT_SPEED);
        s[dwsp_pkg::CFG_SPIN_SPEED]    = dwsp_pkg::CFG_W'(dwsp_pkg::RST_SPIN_SPEED);
        return s;
    endfunction

    task automatic reset_predictor();
        t_cfg_set s;
        s = default_settings();
        for (int k = 0; k < 8; k++)
            cfg_regs[k] = s[k];
        speed_est_l = '0;
        speed_est_r = '0;
        prev_err_l  = '0;
        prev_err_r  = '0;
        drive_acc_l = '0;
        drive_acc_r = '0;
        lost_ticks  = '0;
        is_running  = 1'b0;
    endtask

    // ---------------------------------------------------------------- drivers

    // Writes all eight registers back to back; only called with nothing in flight
    task automatic write_config(input t_cfg_set vals);
        dwsp_pkg::t_cfg_idx idx;
        logic [63:0]        mask;
        for (int k = 0; k < 8; k++) begin
            idx = dwsp_pkg::t_cfg_idx'(k);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            mask = (64'd1 << cfg_width(idx)) - 64'd1;
            cfg_regs[idx] = vals[k] & mask[dwsp_pkg::CFG_W-1:0];
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Valid is left high after acceptance; the next call or wait_idle decides
    task automatic send_item(input t_tick_item it);
        t_drive_result res;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid             <= 1'b1;
        i_req_type             <= it.req;
        i_count_left           <= it.count_l;
        i_count_right          <= it.count_r;
        i_tracker_target_left  <= it.target_l;
        i_tracker_target_right <= it.target_r;
        i_line_lost            <= it.line_lost;
        i_last_line_error      <= it.line_err;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        predict_step(it, res);
        expected_drive_q.push_back(res);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_tick_item make_item(dwsp_pkg::t_req req, int cl, int cr, int tl,
                                             int tr, bit lost, int lerr);
        t_tick_item it;
        it.req       = req;
        it.count_l   = CNT_W'(cl);
        it.count_r   = CNT_W'(cr);
        it.target_l  = dwsp_pkg::TGT_W'(tl);
        it.target_r  = dwsp_pkg::TGT_W'(tr);
        it.line_lost = lost;
        it.line_err  = dwsp_pkg::LERR_W'(lerr);
        return it;
    endfunction

    function automatic t_tick_item noise_item();
        return make_item(dwsp_pkg::t_req'($urandom_range(3)), int'($urandom()),
                         int'($urandom()), int'($urandom()), int'($urandom()),
                         1'($urandom_range(1)), int'($urandom()));
    endfunction

    // Tick with encoder counts near the target speed, as a moving car would give
    function automatic t_tick_item plant_tick(int base_l, int base_r, bit lost);
        t_tick_item it;
        int         tl;
        int         tr;
        tl = base_l + int'($urandom_range(400)) - 200;
        tr = base_r + int'($urandom_range(400)) - 200;
        it = make_item(dwsp_pkg::REQ_TICK,
                       tl / SPEED_PER_COUNT + int'($urandom_range(40)) - 20,
                       -(tr / SPEED_PER_COUNT) + int'($urandom_range(40)) - 20,
                       tl, tr, lost, int'($urandom()));
        if ($urandom_range(15) == 0) begin
            it.count_l = CNT_W'($urandom());
            it.count_r = CNT_W'($urandom());
        end
        return it;
    endfunction

    // Mostly start, runs of tracked or lost line, occasional stop; some noise
    task automatic drive_random_run(input int n_items);
        t_tick_item it;
        int         run_left;
        bit         run_lost;
        int         base_l;
        int         base_r;
        run_left = 0;
        run_lost = 1'b0;
        base_l   = 0;
        base_r   = 0;
        for (int k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                run_lost = ($urandom_range(2) == 0);
                run_left = run_lost ? int'($urandom_range(70, 1))
                                    : int'($urandom_range(30, 1));
                base_l   = int'($urandom_range(20000)) - 10000;
                base_r   = int'($urandom_range(20000)) - 10000;
            end
            run_left--;
            if ($urandom_range(9) == 0)
                it = noise_item();
            else if (!is_running)
                it = ($urandom_range(3) != 0)
                   ? make_item(dwsp_pkg::REQ_START, 0, 0, 0, 0, 0, 0)
                   : plant_tick(base_l, base_r, run_lost);
            else if ($urandom_range(79) == 0)
                it = make_item(dwsp_pkg::REQ_STOP, 0, 0, 0, 0, 0, 0);
            else
                it = plant_tick(base_l, base_r, run_lost);
            send_item(it);
        end
    endtask

    function automatic logic [dwsp_pkg::CFG_W-1:0] pick_value(int hi, int lo, int top);
        case ($urandom_range(15))
            0, 1:    return '0;
            2, 3:    return dwsp_pkg::CFG_W'(top);
            4:       return dwsp_pkg::CFG_W'($urandom());    // bits beyond the register width
            default: return dwsp_pkg::CFG_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic t_cfg_set random_settings();
        t_cfg_set s;
        s[dwsp_pkg::CFG_PROP_GAIN]     = pick_value(300000, 20000, 20'hFFFFF);
        s[dwsp_pkg::CFG_INTEGRAL_GAIN] = pick_value(300000, 20000, 20'hFFFFF);
        s[dwsp_pkg::CFG_DEAD_BAND]     = pick_value(2000, 0, 16'hFFFF);
        s[dwsp_pkg::CFG_DRIVE_LIMIT]   = pick_value(32767, 100, 15'h7FFF);
        s[dwsp_pkg::CFG_SEARCH_TICKS]  = pick_value(30, 0, 16'hFFFF);
        s[dwsp_pkg::CFG_PIVOT_TICKS]   = pick_value(60, 0, 16'hFFFF);
        s[dwsp_pkg::CFG_PIVOT_SPEED]   = pick_value(20000, 0, 16'hFFFF);
        s[dwsp_pkg::CFG_SPIN_SPEED]    = pick_value(20000, 0, 16'hFFFF);
        return s;
    endfunction

    // ---------------------------------------------------------------- checker

    task automatic check_field(input string name,
                               input logic signed [dwsp_pkg::SPD_W-1:0] exp_val,
                               input logic signed [dwsp_pkg::SPD_W-1:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endtask

    // Compare each accepted result with the oldest prediction; stall at random
    always @(posedge i_clk) begin : result_check
        t_drive_result exp_res;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_drive_q.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                exp_res = expected_drive_q.pop_front();
                check_field("drive_left", exp_res.drive_l, o_drive_left);
                check_field("drive_right", exp_res.drive_r, o_drive_right);
                check_field("motors_stopped", exp_res.stopped, o_motors_stopped);
                check_field("recovery_phase", exp_res.phase, o_recovery_phase);
                check_field("speed_left", exp_res.speed_l, o_speed_left);
                check_field("speed_right", exp_res.speed_r, o_speed_right);
            end
        end
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: too long with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- tests

    // Request codes, field extremes, deadband edge and accumulator clamp
    task automatic test_requests_and_limits();
        wait_idle();
        write_config(default_settings());
        set_idling(0, 0);
        send_item(make_item(dwsp_pkg::REQ_NONE, 0, 0, 0, 0, 0, 0));       // unused, stopped
        send_item(make_item(dwsp_pkg::REQ_TICK, 0, 0, 200, -200, 1, 5));  // stopped tick
        send_item(make_item(dwsp_pkg::REQ_START, 1234, -1234, 5000, 5000, 1, 3));
        send_item(make_item(dwsp_pkg::REQ_TICK, 0, 0, 200, -200, 0, 0));  // inside deadband
        send_item(make_item(dwsp_pkg::REQ_TICK, 0, 0, 328, -328, 0, 0));  // on the band edge
        send_item(make_item(dwsp_pkg::REQ_TICK, 100, -100, 6554, 6554, 0, 1));
        send_item(make_item(dwsp_pkg::REQ_NONE, 0, 0, 0, 0, 0, 0));       // unused, running
        send_item(make_item(dwsp_pkg::REQ_TICK, 32767, -32768, 131071, -131072, 0, 127));
        send_item(make_item(dwsp_pkg::REQ_TICK, -32768, 32767, -131072, 131071, 1, -128));
        // drive both accumulators into the clamp
        for (int k = 0; k < 5; k++)
            send_item(make_item(dwsp_pkg::REQ_TICK, -32768, 32767, 131071, 131071, 0, 0));
        send_item(make_item(dwsp_pkg::REQ_NONE, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 3; k++)
            send_item(make_item(dwsp_pkg::REQ_TICK, 32767, -32768, -131072, -131072, 0, 0));
        send_item(make_item(dwsp_pkg::REQ_START, 0, 0, 0, 0, 0, 0));      // restart mid-run
        send_item(make_item(dwsp_pkg::REQ_TICK, 50, -50, 2000, 2000, 0, 0));
        send_item(make_item(dwsp_pkg::REQ_STOP, 0, 0, 0, 0, 0, 0));
        send_item(make_item(dwsp_pkg::REQ_TICK, -7, 9, 9000, -9000, 1, -1)); // filters move
        send_item(make_item(dwsp_pkg::REQ_NONE, 0, 0, 0, 0, 0, 0));
    endtask

    // Search, pivot and spin, both turn directions, reversed and zero thresholds
    task automatic test_recovery_phases();
        t_cfg_set s;
        s = default_settings();
        s[dwsp_pkg::CFG_SEARCH_TICKS] = 1;
        s[dwsp_pkg::CFG_PIVOT_TICKS]  = 3;
        wait_idle();
        write_config(s);
        set_idling(22, 22);
        send_item(make_item(dwsp_pkg::REQ_START, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 5; k++)
            send_item(make_item(dwsp_pkg::REQ_TICK, 20, -20, 3000, 3000, 1, 10));
        send_item(make_item(dwsp_pkg::REQ_TICK, 20, -20, 3000, 3000, 1, -1));
        send_item(make_item(dwsp_pkg::REQ_TICK, 20, -20, 3000, 3000, 1, -128));
        send_item(make_item(dwsp_pkg::REQ_TICK, 20, -20, 3000, 3000, 0, 0)); // line found
        send_item(make_item(dwsp_pkg::REQ_TICK, 20, -20, 3000, 3000, 1, 0));
        send_item(make_item(dwsp_pkg::REQ_TICK, 20, -20, 3000, 3000, 1, 0));
        send_item(make_item(dwsp_pkg::REQ_STOP, 0, 0, 0, 0, 1, 0));          // stop while lost
        send_item(make_item(dwsp_pkg::REQ_START, 0, 0, 0, 0, 0, 0));
        send_item(make_item(dwsp_pkg::REQ_TICK, 20, -20, 3000, 3000, 1, 0));

        // pivot threshold below the search threshold
        s[dwsp_pkg::CFG_SEARCH_TICKS] = 4;
        s[dwsp_pkg::CFG_PIVOT_TICKS]  = 1;
        wait_idle();
        write_config(s);
        send_item(make_item(dwsp_pkg::REQ_START, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 3; k++)
            send_item(make_item(dwsp_pkg::REQ_TICK, -10, 10, -2000, -2000, 1, -5));

        // zero thresholds: spin on the first lost tick
        s[dwsp_pkg::CFG_SEARCH_TICKS] = 0;
        s[dwsp_pkg::CFG_PIVOT_TICKS]  = 0;
        wait_idle();
        write_config(s);
        send_item(make_item(dwsp_pkg::REQ_START, 0, 0, 0, 0, 0, 0));
        send_item(make_item(dwsp_pkg::REQ_TICK, 0, 0, 0, 0, 1, 0));
        send_item(make_item(dwsp_pkg::REQ_TICK, 0, 0, 0, 0, 1, -1));
    endtask

    task automatic test_config_extremes();
        t_cfg_set sets [4];
        sets[0] = '0;
        sets[1] = default_settings();
        sets[1][dwsp_pkg::CFG_PROP_GAIN]     = 20'hFFFFF;
        sets[1][dwsp_pkg::CFG_INTEGRAL_GAIN] = 20'hFFFFF;
        sets[1][dwsp_pkg::CFG_DEAD_BAND]     = 20'hFFFF;
        sets[1][dwsp_pkg::CFG_DRIVE_LIMIT]   = 20'h7FFF;
        sets[1][dwsp_pkg::CFG_SEARCH_TICKS]  = 20'hFFFF;
        sets[1][dwsp_pkg::CFG_PIVOT_TICKS]   = 20'hFFFF;
        sets[1][dwsp_pkg::CFG_PIVOT_SPEED]   = 20'hFFFF;
        sets[1][dwsp_pkg::CFG_SPIN_SPEED]    = 20'hFFFF;
        sets[2] = sets[1];
        sets[2][dwsp_pkg::CFG_DEAD_BAND]     = '0;
        sets[2][dwsp_pkg::CFG_SEARCH_TICKS]  = '0;
        sets[2][dwsp_pkg::CFG_PIVOT_TICKS]   = 2;
        sets[2][dwsp_pkg::CFG_SPIN_SPEED]    = '0;
        sets[3] = default_settings();
        sets[3][dwsp_pkg::CFG_PROP_GAIN]     = '0;
        sets[3][dwsp_pkg::CFG_DEAD_BAND]     = '0;
        sets[3][dwsp_pkg::CFG_DRIVE_LIMIT]   = '0;
        for (int k = 0; k < 4; k++) begin
            wait_idle();
            write_config(sets[k]);
            set_idling(22, 22);
            drive_random_run(80);
        end
    endtask

    // Hold the line lost for a long run; the phase climbs through pivot to spin and stays
    task automatic test_long_line_loss();
        wait_idle();
        write_config(default_settings());
        set_idling(0, 0);
        send_item(make_item(dwsp_pkg::REQ_START, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < LONG_LOSS_TICKS; k++)
            send_item(plant_tick(3000, -3000, 1'b1));
        send_item(plant_tick(3000, -3000, 1'b0));
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            wait_idle();
            write_config(random_settings());
            case (seg % 4)
                0:       set_idling(0, 0);
                1:       set_idling(49, 0);
                2:       set_idling(0, 49);
                default: set_idling(22, 22);
            endcase
            drive_random_run(SEGMENT_ITEMS);
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        errors         = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= dwsp_pkg::CFG_PROP_GAIN;
        i_cfg_data             <= '0;
        i_in_valid             <= 1'b0;
        i_req_type             <= dwsp_pkg::REQ_TICK;
        i_count_left           <= '0;
        i_count_right          <= '0;
        i_tracker_target_left  <= '0;
        i_tracker_target_right <= '0;
        i_line_lost            <= 1'b0;
        i_last_line_error      <= '0;
        reset_predictor();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_requests_and_limits();
        test_recovery_phases();
        test_config_extremes();
        test_long_line_loss();
        test_random_traffic();

        wait_idle();
        repeat (dwsp_pkg::NUM_STAGES + 4) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
